/* hdl/i2s_word_unpack_gain_core_macros.svh */
// Assertion macros used by the merge stage of the capture word unpacker
`ifndef I2S_WORD_UNPACK_GAIN_CORE_MACROS_SVH
`define I2S_WORD_UNPACK_GAIN_CORE_MACROS_SVH

// same-cycle implication under reset
`define IWUG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define IWUG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/iwug_pkg.sv */
// Shared types and constants for the capture word unpacker
package iwug_pkg;

    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_STEREO = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic       DEPTH_RESET  = 1'b1;
    localparam logic       STEREO_RESET = 1'b0;
    localparam logic [6:0] GAIN_RESET   = 7'd32;
    localparam logic [6:0] GAIN_CAP     = 7'd64;

    localparam logic signed [31:0] SAT24_MAX = 32'sd8388607;
    localparam logic signed [31:0] SAT24_MIN = -32'sd8388608;
    localparam logic signed [31:0] SAT16_MAX = 32'sd32767;
    localparam logic signed [31:0] SAT16_MIN = -32'sd32768;

    typedef struct packed {
        logic signed [23:0] first;
        logic signed [23:0] second;
        logic               two;
    } pair_t;

endpackage

/* hdl/iwug_lane.sv */
// One lane: sample x gain (cap 64) saturated to active depth; gain 0 bypasses
module iwug_lane (
    input  logic signed [23:0] sample,
    input  logic               wide,
    input  logic        [6:0]  gain,
    output logic signed [23:0] result
);

    logic        [6:0]  gain_eff;
    logic signed [31:0] sample_ext;
    logic signed [31:0] gain_ext;
    logic signed [31:0] prod;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] sat;

    always_comb
    begin
        gain_eff   = (gain > iwug_pkg::GAIN_CAP) ? iwug_pkg::GAIN_CAP : gain;
        sample_ext = 32'(sample);
        gain_ext   = $signed({25'd0, gain_eff});
        prod       = sample_ext * gain_ext;
        hi         = wide ? iwug_pkg::SAT24_MAX : iwug_pkg::SAT16_MAX;
        lo         = wide ? iwug_pkg::SAT24_MIN : iwug_pkg::SAT16_MIN;
        if (gain_eff == 7'd0)
        begin
            sat = sample_ext;
        end
        else if (prod > hi)
        begin
            sat = hi;
        end
        else if (prod < lo)
        begin
            sat = lo;
        end
        else
        begin
            sat = prod;
        end
        result = sat[23:0];
    end

endmodule

/* hdl/iwug_merge.sv */
// Merge stage: hold the lane results of one word and hand them out in order
`include "i2s_word_unpack_gain_core_macros.svh"

module iwug_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  iwug_pkg::pair_t     pair,
    output logic                can_load,
    output logic signed [23:0]  sample_value,
    output logic                last_of_word,
    output logic                sample_valid,
    input  logic                sample_ready
);

    logic        [1:0]  cnt_reg;
    logic        [1:0]  cnt_next;
    logic signed [23:0] head_reg;
    logic signed [23:0] head_next;
    logic signed [23:0] pend_reg;
    logic signed [23:0] pend_next;
    logic               pop;

    assign pop          = sample_valid && sample_ready;
    assign sample_valid = (cnt_reg != 2'd0);
    assign last_of_word = (cnt_reg == 2'd1);
    assign sample_value = head_reg;
    assign can_load     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && sample_ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        pend_next = pend_reg;
        if (load)
        begin
            head_next = pair.first;
            pend_next = pair.second;
            cnt_next  = pair.two ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            head_next = pend_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        pend_reg <= pend_next;
    end

    `IWUG_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "merge count out of range")
    `IWUG_ASSERT_NEXT(a_load_shows, clk, rst_n, load, sample_valid, "loaded word not shown")
    `IWUG_ASSERT_NEXT(a_second_follows, clk, rst_n, pop && !last_of_word,
        sample_valid && last_of_word && !$past(load), "second sample lost")
    `IWUG_ASSERT_NOW(a_no_overwrite, clk, rst_n, load, can_load, "word loaded over pending samples")

endmodule

/* hdl/i2s_word_unpack_gain_core.sv */
// A word accepted at a clock edge is registered and shows its first sample from the next cycle on.
// Throughput: one sample per cycle while sample_ready is high; a two-sample word gives two samples, others one.
// The two gain lanes work in the accept cycle; the merge stage sets the output rate.
// Reset: rst_n clears the merge stage's sample count and loads depth 24, mono and gain 32.
// The next word is taken in the cycle its predecessor's last sample leaves.
module i2s_word_unpack_gain_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  logic        [31:0] capture_word,
    input  logic               lone_sample,
    input  logic               word_valid,
    output logic               word_ready,
    output logic signed [23:0] sample_value,
    output logic               last_of_word,
    output logic               sample_valid,
    input  logic               sample_ready
);

    logic               depth_reg;
    logic               stereo_reg;
    logic        [6:0]  gain_reg;
    logic               wr;
    logic signed [23:0] first_raw;
    logic signed [23:0] second_raw;
    logic signed [15:0] upper;
    logic signed [15:0] lower;
    logic signed [23:0] first_gained;
    logic signed [23:0] second_gained;
    iwug_pkg::pair_t    pair;
    logic               load;
    logic               can_load;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= iwug_pkg::DEPTH_RESET;
            stereo_reg <= iwug_pkg::STEREO_RESET;
            gain_reg   <= iwug_pkg::GAIN_RESET;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                iwug_pkg::REG_DEPTH:  depth_reg  <= pwdata[0];
                iwug_pkg::REG_STEREO: stereo_reg <= pwdata[0];
                iwug_pkg::REG_GAIN:   gain_reg   <= pwdata[6:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            iwug_pkg::REG_DEPTH:  prdata = {31'd0, depth_reg};
            iwug_pkg::REG_STEREO: prdata = {31'd0, stereo_reg};
            iwug_pkg::REG_GAIN:   prdata = {25'd0, gain_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // split the word into lane samples
    always_comb
    begin
        upper = capture_word[31:16];
        lower = capture_word[15:0];
        if (depth_reg)
        begin
            first_raw  = capture_word[31:8];
            second_raw = 24'(lower);
        end
        else if (stereo_reg)
        begin
            first_raw  = 24'(lower);
            second_raw = 24'(upper);
        end
        else
        begin
            first_raw  = 24'(upper);
            second_raw = 24'(lower);
        end
    end

    iwug_lane u_lane0 (
        .sample (first_raw),
        .wide   (depth_reg),
        .gain   (gain_reg),
        .result (first_gained)
    );

    iwug_lane u_lane1 (
        .sample (second_raw),
        .wide   (depth_reg),
        .gain   (gain_reg),
        .result (second_gained)
    );

    assign pair       = {first_gained, second_gained, !depth_reg && !lone_sample};
    assign word_ready = can_load;
    assign load       = word_valid && can_load;

    iwug_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .pair         (pair),
        .can_load     (can_load),
        .sample_value (sample_value),
        .last_of_word (last_of_word),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready)
    );

endmodule

/* test/i2s_word_unpack_gain_core_check.sv */
// Checker for the capture word unpacker: tracks the registers, predicts samples and compares
module i2s_word_unpack_gain_core_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    input  logic               pready,
    input  logic        [31:0] capture_word,
    input  logic               lone_sample,
    input  logic               word_valid,
    input  logic               word_ready,
    input  logic signed [23:0] sample_value,
    input  logic               last_of_word,
    input  logic               sample_valid,
    input  logic               sample_ready,
    output int                 fail_count,
    output int                 samples_pending,
    output int                 samples_checked
);

    typedef struct packed {
        logic signed [23:0] value;
        logic               last;
    } sample_exp_t;

    sample_exp_t expected_samples[$];

    logic       depth24_q;
    logic       stereo_q;
    logic [6:0] gain_q;

    function automatic logic signed [23:0] gained_sample(input logic signed [23:0] raw,
                                                         input logic wide);
        logic [6:0] g;
        longint     prod;
        longint     hi;
        longint     lo;
        g = (gain_q > iwug_pkg::GAIN_CAP) ? iwug_pkg::GAIN_CAP : gain_q;
        if (g == 7'd0)
        begin
            return raw;
        end
        hi = wide ? longint'(iwug_pkg::SAT24_MAX) : longint'(iwug_pkg::SAT16_MAX);
        lo = wide ? longint'(iwug_pkg::SAT24_MIN) : longint'(iwug_pkg::SAT16_MIN);
        prod = longint'(raw) * longint'(g);
        if (prod > hi)
        begin
            prod = hi;
        end
        if (prod < lo)
        begin
            prod = lo;
        end
        return prod[23:0];
    endfunction

    function automatic void predict_word(input logic [31:0] w, input logic lone);
        logic signed [15:0] first_half;
        logic signed [15:0] second_half;
        if (depth24_q)
        begin
            expected_samples.push_back({gained_sample($signed(w[31:8]), 1'b1), 1'b1});
            return;
        end
        first_half  = stereo_q ? w[15:0] : w[31:16];
        second_half = stereo_q ? w[31:16] : w[15:0];
        if (lone)
        begin
            expected_samples.push_back({gained_sample(24'(first_half), 1'b0), 1'b1});
            return;
        end
        expected_samples.push_back({gained_sample(24'(first_half), 1'b0), 1'b0});
        expected_samples.push_back({gained_sample(24'(second_half), 1'b0), 1'b1});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_exp_t exp_s;
        if (!rst_n)
        begin
            depth24_q       = iwug_pkg::DEPTH_RESET;
            stereo_q        = iwug_pkg::STEREO_RESET;
            gain_q          = iwug_pkg::GAIN_RESET;
            fail_count      = 0;
            samples_checked = 0;
            expected_samples.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    iwug_pkg::REG_DEPTH:  depth24_q = pwdata[0];
                    iwug_pkg::REG_STEREO: stereo_q  = pwdata[0];
                    iwug_pkg::REG_GAIN:   gain_q    = pwdata[6:0];
                    default:              ;
                endcase
            end
            if (word_valid && word_ready)
            begin
                predict_word(capture_word, lone_sample);
            end
            if (sample_valid && sample_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected sample: sample_value %0d last_of_word %0b",
                           sample_value, last_of_word);
                    fail_count++;
                end
                else
                begin
                    exp_s = expected_samples.pop_front();
                    samples_checked++;
                    if (sample_value !== exp_s.value)
                    begin
                        $error("sample_value: expected %0d, actual %0d",
                               exp_s.value, sample_value);
                        fail_count++;
                    end
                    if (last_of_word !== exp_s.last)
                    begin
                        $error("last_of_word: expected %0b, actual %0b",
                               exp_s.last, last_of_word);
                        fail_count++;
                    end
                end
            end
        end
        samples_pending = expected_samples.size();
    end

endmodule

/* test/i2s_word_unpack_gain_core_test.sv */
// Testbench top for the capture word unpacker: clock, reset, stimulus and verdict
module i2s_word_unpack_gain_core_test;

    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 85;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [3:0]  paddr;
    logic        [31:0] pwdata;
    logic        [31:0] prdata;
    logic               pready;
    logic        [31:0] capture_word;
    logic               lone_sample;
    logic               word_valid;
    logic               word_ready;
    logic signed [23:0] sample_value;
    logic               last_of_word;
    logic               sample_valid;
    logic               sample_ready;

    int   fail_count;
    int   samples_pending;
    int   samples_checked;
    int   words_sent;
    int   settings_used;
    int   cycle_count;
    logic idle_on;

    i2s_word_unpack_gain_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .capture_word (capture_word),
        .lone_sample  (lone_sample),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .sample_value (sample_value),
        .last_of_word (last_of_word),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready)
    );

    i2s_word_unpack_gain_core_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .capture_word    (capture_word),
        .lone_sample     (lone_sample),
        .word_valid      (word_valid),
        .word_ready      (word_ready),
        .sample_value    (sample_value),
        .last_of_word    (last_of_word),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .fail_count      (fail_count),
        .samples_pending (samples_pending),
        .samples_checked (samples_checked)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic depth24, input logic stereo, input logic [6:0] gain);
        reg_write(iwug_pkg::REG_DEPTH, {31'd0, depth24});
        reg_write(iwug_pkg::REG_STEREO, {31'd0, stereo});
        reg_write(iwug_pkg::REG_GAIN, {25'd0, gain});
        settings_used++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic lone);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        capture_word <= w;
        lone_sample  <= lone;
        word_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!word_ready);
        words_sent++;
    endtask

    // drop valid, then hold until every predicted sample has left the block
    task automatic drain_words();
        word_valid <= 1'b0;
        @(posedge clk);
        wait (samples_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] short_half();
        int   k;
        logic [15:0] v;
        k = $urandom_range(0, 15);
        v = 16'($urandom) & ((16'd1 << k) - 16'd1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [31:0] random_word();
        logic [15:0] edges [4];
        logic [23:0] v24;
        int          k;
        edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {short_half(), short_half()};
            2:
            begin
                k   = $urandom_range(0, 23);
                v24 = 24'($urandom) & ((24'd1 << k) - 24'd1);
                if ($urandom_range(0, 1))
                begin
                    v24 = -v24;
                end
                return {v24, 8'($urandom)};
            end
            default: return {edges[$urandom_range(0, 3)], edges[$urandom_range(0, 3)]};
        endcase
    endfunction

    function automatic logic [6:0] random_gain();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return 7'd1;
            2: return iwug_pkg::GAIN_CAP;
            3: return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    initial
    begin
        sample_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            int stall;
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                sample_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sample_ready <= 1'b1;
            do
                @(posedge clk);
            while (!sample_valid);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        capture_word  = '0;
        lone_sample   = 1'b0;
        word_valid    = 1'b0;
        idle_on       = 1'b1;
        words_sent    = 0;
        settings_used = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 24-bit, mono, gain 32
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h7FFF_FF00, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_01FF, 1'b0);
        drain_words();

        set_regs(1'b0, 1'b0, 7'd0);
        send_word(32'h7FFF_8000, 1'b0);
        send_word(32'h1234_5678, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        drain_words();

        set_regs(1'b0, 1'b1, 7'd127);
        send_word(32'h7FFF_8000, 1'b0);
        send_word(32'h0001_8000, 1'b1);
        send_word(32'hFFFF_0001, 1'b0);
        send_word(32'h0000_01FF, 1'b0);
        drain_words();

        set_regs(1'b1, 1'b1, iwug_pkg::GAIN_CAP);
        send_word(32'h7FFF_FF00, 1'b1);
        send_word(32'h0000_0100, 1'b0);
        send_word(32'hFFFF_FF00, 1'b0);
        drain_words();

        set_regs(1'b0, 1'b0, 7'd1);
        send_word(32'h8000_7FFF, 1'b0);
        send_word(32'hFFFF_0001, 1'b1);
        send_word(32'hAAAA_5555, 1'b0);
        drain_words();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       set_regs(1'b0, 1'b0, 7'd0);
                1:       set_regs(1'b0, 1'b1, iwug_pkg::GAIN_CAP);
                2:       set_regs(1'b1, 1'b0, 7'd127);
                3:       set_regs(1'b1, 1'b1, 7'd1);
                default: set_regs(1'($urandom), 1'($urandom), random_gain());
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 20 == 0)
                begin
                    idle_on = ($urandom_range(0, 3) != 0);
                end
                send_word(random_word(), $urandom_range(0, 3) == 0);
            end
            idle_on = 1'b1;
            drain_words();
        end

        $display("Sent %0d capture words under %0d register settings.",
                 words_sent, settings_used);
        $display("Checked %0d samples across 24-bit, mono and stereo 16-bit unpacking.",
                 samples_checked);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
